// ===== rtl/core/obbr_pkg.sv =====
// obbr_pkg: shared constants and the quarter-wave sine generator for the
// rotated box versus rectangle overlap pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package obbr_pkg;

    localparam int unsigned FULL_TURN_DEG    = 360;
    localparam int unsigned QUARTER_TURN_DEG = 90;
    localparam int unsigned ANGLE_WIDTH      = 9;
    localparam int unsigned REM_WIDTH        = 7;
    localparam int unsigned SINE_ENTRIES     = 91;
    localparam int unsigned SINE_MAX_WIDTH   = 25;
    localparam logic [63:0] DEG_TO_RAD_Q30   = 64'd18740330;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // Taylor series sine of k degrees, unsigned Q1.f, limited to 1.0
    function automatic logic [SINE_MAX_WIDTH-1:0] quarter_sine(input int k, input int f);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        logic [63:0]        one;
        one = 64'd1 << f;
        if (k == 0)
            return '0;
        if (k >= 90)
            return one[SINE_MAX_WIDTH-1:0];
        x    = 64'(k) * DEG_TO_RAD_Q30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
        if (sum < 0)
            sum = '0;
        r = ($unsigned(sum) + (64'd1 << (29 - f))) >> (30 - f);
        if (r > one)
            r = one;
        return r[SINE_MAX_WIDTH-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/obbr_front.sv =====
// obbr_front: angle reduction, rectangle corner offsets (stage 1) and
// signed sine/cosine lookup by quadrant (stage 2). Uses obbr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module obbr_front #(
    parameter int COORD_WIDTH    = 16,
    parameter int SINE_FRAC_BITS = 15
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [COORD_WIDTH-1:0]     box_center_x,
    input  wire logic signed [COORD_WIDTH-1:0]     box_center_y,
    input  wire logic [COORD_WIDTH-2:0]            box_width,
    input  wire logic [COORD_WIDTH-2:0]            box_height,
    input  wire logic [obbr_pkg::ANGLE_WIDTH-1:0]  box_angle_deg,
    input  wire logic signed [COORD_WIDTH-1:0]     rect_left_x,
    input  wire logic signed [COORD_WIDTH-1:0]     rect_top_y,
    input  wire logic [COORD_WIDTH-2:0]            rect_width,
    input  wire logic [COORD_WIDTH-2:0]            rect_height,
    output logic                                   o_valid,
    input  wire logic                              o_ready,
    output logic signed [COORD_WIDTH+1:0]          qx0,
    output logic signed [COORD_WIDTH+1:0]          qx1,
    output logic signed [COORD_WIDTH+1:0]          qy0,
    output logic signed [COORD_WIDTH+1:0]          qy1,
    output logic [COORD_WIDTH-2:0]                 ext_w,
    output logic [COORD_WIDTH-2:0]                 ext_h,
    output logic signed [SINE_FRAC_BITS+1:0]       sn,
    output logic signed [SINE_FRAC_BITS+1:0]       cs
);
    import obbr_pkg::*;

    localparam int D = COORD_WIDTH + 2;
    localparam int T = SINE_FRAC_BITS + 2;

    logic [SINE_FRAC_BITS:0] sine_rom [SINE_ENTRIES];
    for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_rom
        logic [SINE_MAX_WIDTH-1:0] val;
        assign val         = quarter_sine(k, SINE_FRAC_BITS);
        assign sine_rom[k] = val[SINE_FRAC_BITS:0];
    end

    // stage 1
    logic                    v1_reg;
    logic                    en1;
    logic                    en2;
    quad_t                   quad_reg,  quad_next;
    logic [REM_WIDTH-1:0]    rem_reg,   rem_next;
    logic signed [D-1:0]     qx0_reg, qx1_reg, qy0_reg, qy1_reg;
    logic [COORD_WIDTH-2:0]  bw_reg, bh_reg;
    logic [ANGLE_WIDTH-1:0]  ang;

    logic signed [D-1:0] rx_e, ry_e, cx_e, cy_e, rw_e, rh_e;
    assign rx_e = D'(rect_left_x);
    assign ry_e = D'(rect_top_y);
    assign cx_e = D'(box_center_x);
    assign cy_e = D'(box_center_y);
    assign rw_e = $signed({3'b000, rect_width});
    assign rh_e = $signed({3'b000, rect_height});

    always_comb
    begin
        ang = box_angle_deg;
        if (ang >= ANGLE_WIDTH'(FULL_TURN_DEG))
            ang = ang - ANGLE_WIDTH'(FULL_TURN_DEG);
        priority if (ang < ANGLE_WIDTH'(90))
        begin
            quad_next = QUAD_0;
            rem_next  = REM_WIDTH'(ang);
        end
        else if (ang < ANGLE_WIDTH'(180))
        begin
            quad_next = QUAD_1;
            rem_next  = REM_WIDTH'(ang - ANGLE_WIDTH'(90));
        end
        else if (ang < ANGLE_WIDTH'(270))
        begin
            quad_next = QUAD_2;
            rem_next  = REM_WIDTH'(ang - ANGLE_WIDTH'(180));
        end
        else
        begin
            quad_next = QUAD_3;
            rem_next  = REM_WIDTH'(ang - ANGLE_WIDTH'(270));
        end
    end

    logic v2_reg;
    assign en2      = !v2_reg || o_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en1)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            quad_reg <= quad_next;
            rem_reg  <= rem_next;
            qx0_reg  <= rx_e - cx_e;
            qx1_reg  <= rx_e + rw_e - cx_e;
            qy0_reg  <= ry_e - cy_e;
            qy1_reg  <= ry_e + rh_e - cy_e;
            bw_reg   <= box_width;
            bh_reg   <= box_height;
        end
    end

    // stage 2
    logic signed [T-1:0] s0, c0, sn_next, cs_next;
    logic signed [T-1:0] sn_reg, cs_reg;
    logic signed [D-1:0] qx0_2_reg, qx1_2_reg, qy0_2_reg, qy1_2_reg;
    logic [COORD_WIDTH-2:0] bw2_reg, bh2_reg;

    always_comb
    begin
        s0 = $signed({1'b0, sine_rom[rem_reg]});
        c0 = $signed({1'b0, sine_rom[REM_WIDTH'(QUARTER_TURN_DEG) - rem_reg]});
        unique case (quad_reg)
            QUAD_0:  begin sn_next = s0;  cs_next = c0;  end
            QUAD_1:  begin sn_next = c0;  cs_next = -s0; end
            QUAD_2:  begin sn_next = -s0; cs_next = -c0; end
            default: begin sn_next = -c0; cs_next = s0;  end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            sn_reg    <= sn_next;
            cs_reg    <= cs_next;
            qx0_2_reg <= qx0_reg;
            qx1_2_reg <= qx1_reg;
            qy0_2_reg <= qy0_reg;
            qy1_2_reg <= qy1_reg;
            bw2_reg   <= bw_reg;
            bh2_reg   <= bh_reg;
        end
    end

    assign o_valid = v2_reg;
    assign qx0     = qx0_2_reg;
    assign qx1     = qx1_2_reg;
    assign qy0     = qy0_2_reg;
    assign qy1     = qy1_2_reg;
    assign ext_w   = bw2_reg;
    assign ext_h   = bh2_reg;
    assign sn      = sn_reg;
    assign cs      = cs_reg;
endmodule
`default_nettype wire

// ===== rtl/core/obbr_proj.sv =====
// obbr_proj: corner projections onto both box axes; products (stage 3)
// and per-corner sums (stage 4). Uses obbr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module obbr_proj #(
    parameter int COORD_WIDTH    = 16,
    parameter int SINE_FRAC_BITS = 15
) (
    input  wire logic                                             clk,
    input  wire logic                                             rst_n,
    input  wire logic                                             i_valid,
    output logic                                                  i_ready,
    input  wire logic signed [COORD_WIDTH+1:0]                    qx0,
    input  wire logic signed [COORD_WIDTH+1:0]                    qx1,
    input  wire logic signed [COORD_WIDTH+1:0]                    qy0,
    input  wire logic signed [COORD_WIDTH+1:0]                    qy1,
    input  wire logic [COORD_WIDTH-2:0]                           ext_w,
    input  wire logic [COORD_WIDTH-2:0]                           ext_h,
    input  wire logic signed [SINE_FRAC_BITS+1:0]                 sn,
    input  wire logic signed [SINE_FRAC_BITS+1:0]                 cs,
    output logic                                                  o_valid,
    input  wire logic                                             o_ready,
    output logic signed [COORD_WIDTH+SINE_FRAC_BITS+4:0]          pa [4],
    output logic signed [COORD_WIDTH+SINE_FRAC_BITS+4:0]          pb [4],
    output logic [COORD_WIDTH-2:0]                                ext_w_o,
    output logic [COORD_WIDTH-2:0]                                ext_h_o
);
    import obbr_pkg::*;

    localparam int D = COORD_WIDTH + 2;
    localparam int T = SINE_FRAC_BITS + 2;
    localparam int P = D + T;
    localparam int S = P + 1;

    logic v3_reg, v4_reg, en3, en4;
    assign en4     = !v4_reg || o_ready;
    assign en3     = !v3_reg || en4;
    assign i_ready = en3;

    // axis a = (cs, -sn), axis b = (sn, cs)
    logic signed [P-1:0] cx0_reg, cx1_reg, sy0_reg, sy1_reg;
    logic signed [P-1:0] sx0_reg, sx1_reg, cy0_reg, cy1_reg;
    logic [COORD_WIDTH-2:0] bw3_reg, bh3_reg, bw4_reg, bh4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en3)
                v3_reg <= i_valid;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && i_valid)
        begin
            cx0_reg <= P'(cs) * P'(qx0);
            cx1_reg <= P'(cs) * P'(qx1);
            sy0_reg <= P'(sn) * P'(qy0);
            sy1_reg <= P'(sn) * P'(qy1);
            sx0_reg <= P'(sn) * P'(qx0);
            sx1_reg <= P'(sn) * P'(qx1);
            cy0_reg <= P'(cs) * P'(qy0);
            cy1_reg <= P'(cs) * P'(qy1);
            bw3_reg <= ext_w;
            bh3_reg <= ext_h;
        end
    end

    logic signed [S-1:0] pa_reg [4];
    logic signed [S-1:0] pb_reg [4];

    always_ff @(posedge clk)
    begin
        if (en4 && v3_reg)
        begin
            pa_reg[0] <= S'(cx0_reg) - S'(sy0_reg);
            pa_reg[1] <= S'(cx1_reg) - S'(sy0_reg);
            pa_reg[2] <= S'(cx1_reg) - S'(sy1_reg);
            pa_reg[3] <= S'(cx0_reg) - S'(sy1_reg);
            pb_reg[0] <= S'(sx0_reg) + S'(cy0_reg);
            pb_reg[1] <= S'(sx1_reg) + S'(cy0_reg);
            pb_reg[2] <= S'(sx1_reg) + S'(cy1_reg);
            pb_reg[3] <= S'(sx0_reg) + S'(cy1_reg);
            bw4_reg   <= bw3_reg;
            bh4_reg   <= bh3_reg;
        end
    end

    assign o_valid = v4_reg;
    assign pa      = pa_reg;
    assign pb      = pb_reg;
    assign ext_w_o = bw4_reg;
    assign ext_h_o = bh4_reg;
endmodule
`default_nettype wire

// ===== rtl/core/obbr_sep.sv =====
// obbr_sep: min/max of projections per axis and the separation compare
// against the box half extent; result register (stage 5). Uses obbr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module obbr_sep #(
    parameter int COORD_WIDTH    = 16,
    parameter int SINE_FRAC_BITS = 15
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     i_valid,
    output logic                                          i_ready,
    input  wire logic signed [COORD_WIDTH+SINE_FRAC_BITS+4:0] pa [4],
    input  wire logic signed [COORD_WIDTH+SINE_FRAC_BITS+4:0] pb [4],
    input  wire logic [COORD_WIDTH-2:0]                   ext_w,
    input  wire logic [COORD_WIDTH-2:0]                   ext_h,
    output logic                                          out_valid,
    input  wire logic                                     out_ready,
    output logic                                          overlap
);
    import obbr_pkg::*;

    localparam int S = COORD_WIDTH + SINE_FRAC_BITS + 5;
    localparam int C = S + 2;

    function automatic logic separates(input logic signed [S-1:0] p [4],
                                       input logic [COORD_WIDTH-2:0] ext);
        logic signed [S-1:0] mn;
        logic signed [S-1:0] mx;
        logic signed [C-1:0] lim;
        logic signed [C-1:0] mn2;
        logic signed [C-1:0] mx2;
        mn = p[0];
        mx = p[0];
        for (int i = 1; i < 4; i++)
        begin
            if (p[i] < mn)
                mn = p[i];
            if (p[i] > mx)
                mx = p[i];
        end
        lim = C'($signed({1'b0, ext})) <<< SINE_FRAC_BITS;
        mn2 = C'(mn) <<< 1;
        mx2 = C'(mx) <<< 1;
        return (ext != '0) && ((mn2 > lim) || (mx2 < -lim));
    endfunction

    logic v_reg, ov_reg, en;
    assign en      = !v_reg || out_ready;
    assign i_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= i_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && i_valid)
            ov_reg <= !(separates(pa, ext_w) || separates(pb, ext_h));
    end

    assign out_valid = v_reg;
    assign overlap   = ov_reg;
endmodule
`default_nettype wire

// ===== rtl/core/rotated_box_vs_rect_overlap.sv =====
// rotated_box_vs_rect_overlap: top level of the box/rectangle overlap pipeline.
// Instantiates obbr_front, obbr_proj and obbr_sep; uses obbr_pkg.
//
// Usage:
//   Input channel in_valid/in_ready carries one item: a rotated box (center,
//   size, angle in degrees) and an axis-aligned rectangle (top-left, size).
//   Output channel out_valid/out_ready returns one item per input: overlap.
//   Pipeline: 5 register stages (angle/offsets, trig lookup, axis products,
//   corner sums, min/max compare), and the result register drives out_valid.
//   Throughput: one item per cycle while out_ready stays high; every stage holds
//   a valid bit and advances when the stage after it is empty or moving.
//   Stall: when out_ready is low the result holds; earlier stages keep
//   filling bubbles, and in_ready drops only when all five stages are full.
//   Reset clears all valid bits; no item is in flight after reset.
`timescale 1ns / 1ps
`default_nettype none
module rotated_box_vs_rect_overlap #(
    parameter int COORD_WIDTH    = 16,
    parameter int SINE_FRAC_BITS = 15
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [COORD_WIDTH-1:0]     box_center_x,
    input  wire logic signed [COORD_WIDTH-1:0]     box_center_y,
    input  wire logic [COORD_WIDTH-2:0]            box_width,
    input  wire logic [COORD_WIDTH-2:0]            box_height,
    input  wire logic [obbr_pkg::ANGLE_WIDTH-1:0]  box_angle_deg,
    input  wire logic signed [COORD_WIDTH-1:0]     rect_left_x,
    input  wire logic signed [COORD_WIDTH-1:0]     rect_top_y,
    input  wire logic [COORD_WIDTH-2:0]            rect_width,
    input  wire logic [COORD_WIDTH-2:0]            rect_height,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   overlap
);
    import obbr_pkg::*;

    localparam int D = COORD_WIDTH + 2;
    localparam int T = SINE_FRAC_BITS + 2;
    localparam int S = D + T + 1;

    logic                   f_valid, f_ready, p_valid, p_ready;
    logic signed [D-1:0]    qx0, qx1, qy0, qy1;
    logic [COORD_WIDTH-2:0] f_w, f_h, p_w, p_h;
    logic signed [T-1:0]    sn, cs;
    logic signed [S-1:0]    pa [4];
    logic signed [S-1:0]    pb [4];

    obbr_front #(.COORD_WIDTH(COORD_WIDTH), .SINE_FRAC_BITS(SINE_FRAC_BITS)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .box_center_x  (box_center_x),
        .box_center_y  (box_center_y),
        .box_width     (box_width),
        .box_height    (box_height),
        .box_angle_deg (box_angle_deg),
        .rect_left_x   (rect_left_x),
        .rect_top_y    (rect_top_y),
        .rect_width    (rect_width),
        .rect_height   (rect_height),
        .o_valid       (f_valid),
        .o_ready       (f_ready),
        .qx0           (qx0),
        .qx1           (qx1),
        .qy0           (qy0),
        .qy1           (qy1),
        .ext_w         (f_w),
        .ext_h         (f_h),
        .sn            (sn),
        .cs            (cs)
    );

    obbr_proj #(.COORD_WIDTH(COORD_WIDTH), .SINE_FRAC_BITS(SINE_FRAC_BITS)) u_proj (
        .clk     (clk),
        .rst_n   (rst_n),
        .i_valid (f_valid),
        .i_ready (f_ready),
        .qx0     (qx0),
        .qx1     (qx1),
        .qy0     (qy0),
        .qy1     (qy1),
        .ext_w   (f_w),
        .ext_h   (f_h),
        .sn      (sn),
        .cs      (cs),
        .o_valid (p_valid),
        .o_ready (p_ready),
        .pa      (pa),
        .pb      (pb),
        .ext_w_o (p_w),
        .ext_h_o (p_h)
    );

    obbr_sep #(.COORD_WIDTH(COORD_WIDTH), .SINE_FRAC_BITS(SINE_FRAC_BITS)) u_sep (
        .clk       (clk),
        .rst_n     (rst_n),
        .i_valid   (p_valid),
        .i_ready   (p_ready),
        .pa        (pa),
        .pb        (pb),
        .ext_w     (p_w),
        .ext_h     (p_h),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .overlap   (overlap)
    );
endmodule
`default_nettype wire

// ===== sim/obbr_overlap_checker.sv =====
// obbr_overlap_checker: watches both channels of rotated_box_vs_rect_overlap,
// predicts overlap for each accepted item and compares. Uses obbr_pkg types.
`timescale 1ns / 1ps
module obbr_overlap_checker #(
    parameter int COORD_WIDTH    = 16,
    parameter int SINE_FRAC_BITS = 15
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] box_center_x,
    input  logic signed [COORD_WIDTH-1:0] box_center_y,
    input  logic [COORD_WIDTH-2:0]        box_width,
    input  logic [COORD_WIDTH-2:0]        box_height,
    input  logic [8:0]                    box_angle_deg,
    input  logic signed [COORD_WIDTH-1:0] rect_left_x,
    input  logic signed [COORD_WIDTH-1:0] rect_top_y,
    input  logic [COORD_WIDTH-2:0]        rect_width,
    input  logic [COORD_WIDTH-2:0]        rect_height,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          overlap,
    output int                            errors,
    output int                            pending
);
    import obbr_pkg::*;

    logic  expected_overlap[$];
    longint sine_lut[0:90];

    function automatic longint taylor_sine(int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint sum;
        longint r;
        longint one;
        one = longint'(1) << SINE_FRAC_BITS;
        if (k == 0)
            return 0;
        if (k >= 90)
            return one;
        x = longint'(k) * 64'd18740330;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int n = 1; n <= 7; n++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = (sum + (longint'(1) << (29 - SINE_FRAC_BITS))) >>> (30 - SINE_FRAC_BITS);
        return (r > one) ? one : r;
    endfunction

    initial
    begin
        for (int k = 0; k <= 90; k++)
            sine_lut[k] = taylor_sine(k);
    end

    function automatic bit axis_splits(longint ax, longint ay, longint qx[4],
                                       longint qy[4], longint extent);
        longint pmin;
        longint pmax;
        longint p;
        longint lim;
        if (extent == 0)
            return 0;
        pmin = ax * qx[0] + ay * qy[0];
        pmax = pmin;
        for (int i = 1; i < 4; i++)
        begin
            p = ax * qx[i] + ay * qy[i];
            if (p > pmax) pmax = p;
            if (p < pmin) pmin = p;
        end
        lim = extent * (longint'(1) << SINE_FRAC_BITS);
        return (2 * pmin > lim) || (2 * pmax < -lim);
    endfunction

    function automatic logic predict_overlap();
        longint cx, cy, rx, ry, rw, rh, s0, c0, sn, cs;
        longint qx[4];
        longint qy[4];
        int ang;
        quad_t quad;
        int rem;
        cx = box_center_x;
        cy = box_center_y;
        rx = rect_left_x;
        ry = rect_top_y;
        rw = rect_width;
        rh = rect_height;
        ang = box_angle_deg % FULL_TURN_DEG;
        quad = quad_t'(ang / QUARTER_TURN_DEG);
        rem = ang % QUARTER_TURN_DEG;
        s0 = sine_lut[rem];
        c0 = sine_lut[90 - rem];
        case (quad)
            QUAD_0: begin sn = s0;  cs = c0;  end
            QUAD_1: begin sn = c0;  cs = -s0; end
            QUAD_2: begin sn = -s0; cs = -c0; end
            default: begin sn = -c0; cs = s0; end
        endcase
        qx[0] = rx - cx;      qy[0] = ry - cy;
        qx[1] = rx + rw - cx; qy[1] = ry - cy;
        qx[2] = rx + rw - cx; qy[2] = ry + rh - cy;
        qx[3] = rx - cx;      qy[3] = ry + rh - cy;
        return !(axis_splits(cs, -sn, qx, qy, longint'(box_width)) ||
                 axis_splits(sn, cs, qx, qy, longint'(box_height)));
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        errors++;
    endtask

    initial
        errors = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_overlap.size() == 0)
                    report_mismatch("result with no item outstanding");
                else if (overlap !== expected_overlap[0])
                begin
                    report_mismatch($sformatf("overlap %b, want %b", overlap,
                                              expected_overlap[0]));
                    void'(expected_overlap.pop_front());
                end
                else
                    void'(expected_overlap.pop_front());
            end
            if (in_valid && in_ready)
                expected_overlap.push_back(predict_overlap());
        end
        pending <= expected_overlap.size();
    end
endmodule

// ===== sim/rotated_box_vs_rect_overlap_test.sv =====
// rotated_box_vs_rect_overlap_test: stimulus and verdict for the overlap
// pipeline. Depends on obbr_pkg, rotated_box_vs_rect_overlap, obbr_overlap_checker.
`timescale 1ns / 1ps
module rotated_box_vs_rect_overlap_test;
    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_ready;
    logic signed [15:0] box_center_x = 0;
    logic signed [15:0] box_center_y = 0;
    logic [14:0]        box_width = 0;
    logic [14:0]        box_height = 0;
    logic [8:0]         box_angle_deg = 0;
    logic signed [15:0] rect_left_x = 0;
    logic signed [15:0] rect_top_y = 0;
    logic [14:0]        rect_width = 0;
    logic [14:0]        rect_height = 0;
    logic               out_valid;
    logic               out_ready = 0;
    logic               overlap;
    int                 errors;
    int                 pending;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    bit                 hold_off = 0;

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    rotated_box_vs_rect_overlap DUT (.*);
    obbr_overlap_checker checker_i (.*);

    always @(posedge clk)
        out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    task automatic send_item(logic signed [15:0] cx, logic signed [15:0] cy,
                             logic [14:0] bw, logic [14:0] bh, logic [8:0] ang,
                             logic signed [15:0] rx, logic signed [15:0] ry,
                             logic [14:0] rw, logic [14:0] rh);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        box_center_x <= cx;  box_center_y <= cy;
        box_width <= bw;     box_height <= bh;
        box_angle_deg <= ang;
        rect_left_x <= rx;   rect_top_y <= ry;
        rect_width <= rw;    rect_height <= rh;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_random();
        logic signed [15:0] cx, cy;
        logic [14:0] bw, bh, rw, rh;
        if ($urandom_range(3) == 0)
        begin
            send_item(16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
                      9'($urandom), 16'($urandom), 16'($urandom), 15'($urandom),
                      15'($urandom));
        end
        else
        begin
            // nearby shapes so both outcomes are common
            cx = $signed(16'($urandom_range(8000))) - 16'sd4000;
            cy = $signed(16'($urandom_range(8000))) - 16'sd4000;
            bw = 15'($urandom_range(3000));
            bh = 15'($urandom_range(3000));
            rw = 15'($urandom_range(3000));
            rh = 15'($urandom_range(3000));
            send_item(cx, cy, bw, bh, 9'($urandom_range(511)),
                      cx + $signed(16'($urandom_range(6000))) - 16'sd3000 - 16'(rw / 2),
                      cy + $signed(16'($urandom_range(6000))) - 16'sd3000 - 16'(rh / 2),
                      rw, rh);
        end
    endtask

    initial
    begin
        int hold_cycles;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // extremes, every quadrant, zero sizes, touching edges, wrap of angle
        send_item(0, 0, 160, 160, 0, 80, 0, 16, 16);
        send_item(0, 0, 160, 160, 0, 81, 0, 16, 16);
        send_item(0, 0, 160, 160, 0, -96, -96, 16, 16);
        send_item(0, 0, 160, 160, 0, -97, -97, 16, 16);
        send_item(0, 0, 0, 0, 45, 30000, 30000, 1, 1);
        send_item(0, 0, 0, 500, 0, 3000, 0, 10, 10);
        send_item(0, 0, 500, 0, 0, 0, 3000, 10, 10);
        send_item(0, 0, 1600, 160, 90, 0, 500, 16, 16);
        send_item(0, 0, 1600, 160, 180, 500, 0, 16, 16);
        send_item(0, 0, 1600, 160, 270, 0, 500, 16, 16);
        send_item(0, 0, 1600, 160, 45, 500, 500, 16, 16);
        send_item(0, 0, 1600, 160, 135, 500, 500, 16, 16);
        send_item(0, 0, 1600, 160, 225, 500, 500, 16, 16);
        send_item(0, 0, 1600, 160, 315, 500, 500, 16, 16);
        send_item(0, 0, 1600, 160, 359, 700, 0, 16, 16);
        send_item(0, 0, 1600, 160, 360, 700, 0, 16, 16);
        send_item(0, 0, 1600, 160, 405, 500, 500, 16, 16);
        send_item(0, 0, 1600, 160, 511, 500, 500, 16, 16);
        send_item(-32768, -32768, 32767, 32767, 89, 32767, 32767, 32767, 32767);
        send_item(32767, 32767, 32767, 32767, 1, -32768, -32768, 32767, 32767);
        send_item(-32768, 32767, 32767, 0, 179, 32767, -32768, 0, 32767);
        send_item(32767, -32768, 0, 32767, 271, -32768, 32767, 32767, 0);
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 22 : 47) : 0;
            recv_stall_pct = (phase == 2) ? 47 : ((phase == 3) ? 22 : 0);
            for (int i = 0; i < 180; i++)
                send_random();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1;
        fork
            begin
                for (hold_cycles = 0; hold_cycles < 60; hold_cycles++)
                    @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 20; i++)
                send_random();
        join
        in_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
